/* hw/rtl/lcs_pkg.sv */
// Shared constants and types for the LCS length cell chain.
`default_nettype none
package lcs_pkg;

	localparam int MAX_LEN = 64;
	localparam int SYM_W   = 8;
	localparam int POS_W   = 6;
	localparam int ROW_W   = 7;
	localparam int CFG_W   = 7;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_B    = 1'b1;

	// Wavefront token handed from one cell to the next.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic [SYM_W-1:0] sym;
		logic [ROW_W-1:0] diag;
		logic [ROW_W-1:0] left;
	} tok_t;

endpackage
`default_nettype wire

/* hw/rtl/lcs_cell.sv */
// One table cell: holds one A symbol and its entry of the previous row.
`default_nettype none
module lcs_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       en,
	input  wire logic                       clear,
	input  wire logic                       load_en,
	input  wire logic [lcs_pkg::SYM_W-1:0] load_sym,
	input  wire lcs_pkg::tok_t              tok_in,
	output      lcs_pkg::tok_t              tok_out
);

	logic [lcs_pkg::SYM_W-1:0] a_sym_q;
	logic [lcs_pkg::ROW_W-1:0] row_q;
	logic [lcs_pkg::ROW_W-1:0] cell_val;
	logic                      take;

	assign take = advance & tok_in.valid & en;

	always_comb begin
		if (a_sym_q == tok_in.sym) begin
			cell_val = tok_in.diag + lcs_pkg::ROW_W'(1);
		end else if (tok_in.left > row_q) begin
			cell_val = tok_in.left;
		end else begin
			cell_val = row_q;
		end
	end

	// load A symbol; store is undefined until written
	always_ff @(posedge clk) begin
		if (load_en) begin
			a_sym_q <= load_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (clear) begin
			row_q <= '0;
		end else if (take) begin
			row_q <= cell_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else if (advance) begin
			tok_out.valid <= tok_in.valid & en;
			tok_out.last  <= tok_in.last;
			tok_out.sym   <= tok_in.sym;
			tok_out.diag  <= row_q;
			tok_out.left  <= cell_val;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lcs_length_dp_core.sv */
// LCS length core: a chain of MAX_LEN cells that a B symbol sweeps through.
// A B symbol's wavefront walks the active cells one cell per cycle to the tail cell (straight
// to the output register if seq_a_len is 0), stalling while a finished token waits for the
// output register. A new request, load or B symbol, is taken only with the chain empty.
// Reset (arst_n low, asynchronous): row entries cleared, seq_a_len = 1, nothing in flight.
// The A symbol store is undefined until loaded.
`default_nettype none
module lcs_length_dp_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration: seq_a_len
	input  wire logic                       cfg_we,
	input  wire logic [lcs_pkg::CFG_W-1:0] cfg_wdata,
	// input requests
	input  wire logic                       s_axis_tvalid,
	output      logic                       s_axis_tready,
	input  wire logic [15:0]                s_axis_tdata,  // symbol[7:0], position[13:8], zero pad
	input  wire logic                       s_axis_tuser,  // kind
	input  wire logic                       s_axis_tlast,  // last
	// result requests
	output      logic                       m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output      logic [7:0]                 m_axis_tdata,  // lcs_length[6:0], zero pad
	output      logic                       m_axis_tlast   // final_res
);

	localparam int N = lcs_pkg::MAX_LEN;

	// unpack the request
	logic [lcs_pkg::SYM_W-1:0] in_sym;
	logic [lcs_pkg::POS_W-1:0] in_pos;
	assign in_sym = s_axis_tdata[lcs_pkg::SYM_W-1:0];
	assign in_pos = s_axis_tdata[lcs_pkg::SYM_W +: lcs_pkg::POS_W];

	// mask_q[j] is set when cell j takes part (j < seq_a_len, saturated at N)
	logic [N-1:0] mask_q;
	logic [N-1:0] tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= N'(1);
		end else if (cfg_we) begin
			for (int j = 0; j < N; j++) begin
				mask_q[j] <= (int'(cfg_wdata) > j);
			end
		end
	end

	// the tail cell is the last active one; its token is the result
	assign tail = mask_q & ~(mask_q >> 1);

	logic busy_q;
	logic out_valid_q;
	logic [lcs_pkg::ROW_W-1:0] out_len_q;
	logic out_last_q;

	logic accept;
	logic accept_b;
	logic len0_res;
	logic advance;
	logic capture;
	logic clear;

	lcs_pkg::tok_t head;
	lcs_pkg::tok_t chain [N];

	logic                      tail_valid;
	logic                      tail_last;
	logic [lcs_pkg::ROW_W-1:0] tail_left;

	// pick out the token sitting at the tail cell
	always_comb begin
		tail_valid = 1'b0;
		tail_last  = 1'b0;
		tail_left  = '0;
		for (int j = 0; j < N; j++) begin
			if (tail[j] && chain[j].valid) begin
				tail_valid = 1'b1;
				tail_last  = tail_last | chain[j].last;
				tail_left  = tail_left | chain[j].left;
			end
		end
	end

	// take a new request only with the chain empty; with no active cells the
	// result goes straight to the output register, so it must be free
	assign s_axis_tready = !busy_q && (mask_q[0] || !out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign accept_b      = accept & (s_axis_tuser == lcs_pkg::KIND_B);
	assign len0_res      = accept_b & ~mask_q[0];

	// hold the whole chain while a finished token waits for the output register
	assign advance = !(tail_valid && out_valid_q && !m_axis_tready);
	assign capture = tail_valid & advance;

	// drop the row after the last B symbol's result is taken in
	assign clear = (capture & tail_last) | (len0_res & s_axis_tlast);

	always_comb begin
		head       = '0;
		head.valid = accept_b;
		head.last  = s_axis_tlast;
		head.sym   = in_sym;
	end

	for (genvar j = 0; j < N; j++) begin : g_cell
		lcs_pkg::tok_t cell_in;
		logic          load_en;

		if (j == 0) begin : g_first
			assign cell_in = head;
		end else begin : g_next
			assign cell_in = chain[j-1];
		end

		assign load_en = accept && (s_axis_tuser == lcs_pkg::KIND_LOAD)
			&& (int'(in_pos) == j);

		lcs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.en       (mask_q[j]),
			.clear    (clear),
			.load_en  (load_en),
			.load_sym (in_sym),
			.tok_in   (cell_in),
			.tok_out  (chain[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (capture) begin
			busy_q <= 1'b0;
		end else if (accept_b && mask_q[0]) begin
			busy_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (capture || len0_res) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_len_q  <= tail_left;
			out_last_q <= tail_last;
		end else if (len0_res) begin
			out_len_q  <= '0;
			out_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_len_q};
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

/* tb/lcs_length_dp_core_tb.sv */
// Self-checking bench for lcs_length_dp_core: directed request table, then random string traffic.
module lcs_length_dp_core_tb;
	import lcs_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 11;
	// a sweep walks up to MAX_LEN cells; the padding covers the output register
	localparam int SETTLE_CYCLES   = MAX_LEN + 8;
	localparam int STALL_LIMIT     = 4000;
	localparam int RANDOM_REQUESTS = 900;

	typedef struct packed {
		logic [ROW_W-1:0] length;
		logic             fin;
	} lcs_result_t;

	typedef enum logic [1:0] {STEP_LOAD, STEP_SYMBOL, STEP_CFG} step_t;

	// val is the symbol for LOAD/SYMBOL rows and the new seq_a_len for CFG rows
	typedef struct {
		step_t            op;
		logic [7:0]       val;
		logic [POS_W-1:0] pos;
		logic             last;
		bit               typed;
		logic [ROW_W-1:0] exp_len;
		logic             exp_fin;
	} script_row_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_we        = 1'b0;
	logic [CFG_W-1:0] cfg_wdata     = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [15:0]      s_axis_tdata  = '0;	// symbol[7:0], position[13:8], zero pad
	logic             s_axis_tuser  = 1'b0;	// kind
	logic             s_axis_tlast  = 1'b0;	// last
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;		// lcs_length[6:0], zero pad
	logic             m_axis_tlast;		// final_res

	// shadow of the block: A symbols, the one kept row, and the length register
	logic [SYM_W-1:0] a_sym [MAX_LEN];
	logic [ROW_W-1:0] dp_row [MAX_LEN];
	logic [CFG_W-1:0] len_setting;

	lcs_result_t pending_lengths [$];
	int unsigned fail_count      = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct  = 0;

	// directed requests; typed expectations only where the answer is obvious
	script_row_t script [21] = '{
		'{STEP_LOAD,   8'h00, 6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'h00, 6'd0,  1'b0, 1'b1, 7'd1, 1'b0},	// match against A[0]
		'{STEP_SYMBOL, 8'hFF, 6'd0,  1'b1, 1'b1, 7'd1, 1'b1},	// length holds, string ends
		'{STEP_SYMBOL, 8'hFF, 6'd63, 1'b1, 1'b1, 7'd0, 1'b1},	// row was cleared
		'{STEP_LOAD,   8'hFF, 6'd63, 1'b1, 1'b0, 7'd0, 1'b0},	// last on a load is ignored
		'{STEP_LOAD,   8'hFF, 6'd1,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_CFG,    8'd2,  6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'hFF, 6'd0,  1'b0, 1'b1, 7'd1, 1'b0},
		'{STEP_SYMBOL, 8'h00, 6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'hFF, 6'd0,  1'b1, 1'b1, 7'd2, 1'b1},	// "00 FF" vs "FF 00 FF"
		'{STEP_CFG,    8'd0,  6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'h00, 6'd0,  1'b1, 1'b1, 7'd0, 1'b1},	// zero length compares nothing
		'{STEP_CFG,    8'd2,  6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'h00, 6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_CFG,    8'd1,  6'd0,  1'b0, 1'b0, 7'd0, 1'b0},	// shrink in the middle of B
		'{STEP_SYMBOL, 8'h00, 6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_CFG,    8'd2,  6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_SYMBOL, 8'hFF, 6'd0,  1'b1, 1'b0, 7'd0, 1'b0},	// stale entry beyond old length used
		'{STEP_SYMBOL, 8'h5A, 6'd42, 1'b1, 1'b1, 7'd0, 1'b1},	// position ignored on B
		'{STEP_LOAD,   8'hA5, 6'd42, 1'b0, 1'b0, 7'd0, 1'b0},
		'{STEP_LOAD,   8'h5A, 6'd21, 1'b0, 1'b0, 7'd0, 1'b0}
	};

	lcs_length_dp_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Advance the shadow by one accepted request. Loads store a symbol; a B symbol sweeps
	// the kept row and yields the last cell, clearing the row when the string ends.
	function automatic bit update_lcs_row(input logic kind, input logic [SYM_W-1:0] sym,
			input logic [POS_W-1:0] pos, input logic last, output lcs_result_t res);
		int               span;
		logic [ROW_W-1:0] diag;
		logic [ROW_W-1:0] left;
		logic [ROW_W-1:0] up;
		span = (len_setting > MAX_LEN) ? MAX_LEN : int'(len_setting);
		diag = '0;
		left = '0;
		res  = '0;
		if (kind == KIND_LOAD) begin
			if (pos < MAX_LEN)
				a_sym[pos] = sym;
			return 1'b0;
		end
		for (int j = 0; j < span; j++) begin
			up = dp_row[j];
			if (a_sym[j] == sym)
				dp_row[j] = diag + 1'b1;
			else
				dp_row[j] = (left > up) ? left : up;
			diag = up;
			left = dp_row[j];
		end
		res.length = left;
		res.fin    = last;
		if (last)
			foreach (dp_row[j]) dp_row[j] = '0;
		return 1'b1;
	endfunction

	// mostly a tiny alphabet so matches are common; sometimes any byte
	function automatic logic [SYM_W-1:0] pick_symbol();
		logic [SYM_W-1:0] alphabet [4] = '{8'h00, 8'hFF, 8'h41, 8'h42};
		if ($urandom_range(99) < 15)
			return SYM_W'($urandom);
		return alphabet[$urandom_range(3)];
	endfunction

	// first phases hit the extremes, then mostly short rows to keep the sweep fast
	function automatic logic [CFG_W-1:0] pick_length(input int phase);
		int r;
		r = $urandom_range(99);
		case (phase)
			0: return CFG_W'(MAX_LEN);
			1: return '1;		// above MAX_LEN, saturates
			2: return '0;
			3: return CFG_W'(1);
			default: begin
				if (r < 70)
					return CFG_W'($urandom_range(1, 8));
				if (r < 90)
					return CFG_W'($urandom_range(9, MAX_LEN));
				return CFG_W'($urandom_range(0, 127));
			end
		endcase
	endfunction

	// Offer one request, hold it until taken, then record what it should produce.
	task automatic send_request(input logic kind, input logic [SYM_W-1:0] sym,
			input logic [POS_W-1:0] pos, input logic last, input bit typed = 1'b0,
			input lcs_result_t typed_res = '0);
		int          gap;
		lcs_result_t res;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, pos, sym};
		s_axis_tuser  <= kind;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (update_lcs_row(kind, sym, pos, last, res))
			pending_lengths.push_back(typed ? typed_res : res);
	endtask

	// Drop valid and hold off until every outstanding result has come back.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_lengths.size() != 0);
	endtask

	// Drain, then let any trailing load or sweep finish before touching the register.
	task automatic settle_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seq_a_len(input logic [CFG_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we      <= 1'b0;
		len_setting = value;
	endtask

	// result side: compare against the oldest expectation, stall at random
	always @(posedge clk) begin : take_result
		lcs_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_lengths.size() == 0) begin
				$error("unexpected result: lcs_length %0d final_res %0b",
					m_axis_tdata[ROW_W-1:0], m_axis_tlast);
				fail_count++;
			end else begin
				want = pending_lengths.pop_front();
				if (m_axis_tdata[ROW_W-1:0] !== want.length) begin
					$error("lcs_length: expected %0d, actual %0d",
						want.length, m_axis_tdata[ROW_W-1:0]);
					fail_count++;
				end
				if (m_axis_tlast !== want.fin) begin
					$error("final_res: expected %0b, actual %0b", want.fin, m_axis_tlast);
					fail_count++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: end the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int  requests;
		int  phase;
		int  phase_end;
		int  choice;
		int  str_len;
		bit  paused;
		foreach (a_sym[j]) a_sym[j] = '0;
		foreach (dp_row[j]) dp_row[j] = '0;
		len_setting = CFG_W'(1);
		requests    = 0;
		phase       = 0;
		paused      = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (script[i]) begin
			case (script[i].op)
				STEP_CFG: begin
					settle_idle();
					write_seq_a_len(script[i].val[CFG_W-1:0]);
				end
				STEP_LOAD: begin
					send_request(KIND_LOAD, script[i].val, script[i].pos, script[i].last);
				end
				default: begin
					send_request(KIND_B, script[i].val, script[i].pos, script[i].last,
						script[i].typed, {script[i].exp_len, script[i].exp_fin});
				end
			endcase
		end

		// fill every A position so no B symbol ever reads an unwritten entry
		for (int p = 0; p < MAX_LEN; p++) begin
			send_request(KIND_LOAD, pick_symbol(), POS_W'(p), 1'($urandom_range(1)));
			requests++;
		end

		while (requests < RANDOM_REQUESTS) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			settle_idle();
			write_seq_a_len(pick_length(phase));
			phase_end = requests + 40 + $urandom_range(40);
			while (requests < phase_end) begin
				choice = $urandom_range(99);
				if (choice < 15) begin
					// rewrite a few A symbols between strings
					repeat ($urandom_range(1, 4)) begin
						send_request(KIND_LOAD, pick_symbol(), POS_W'($urandom),
							1'($urandom_range(1)));
						requests++;
					end
				end else if (choice < 85) begin
					// well-formed B string closed by last
					str_len = $urandom_range(1, 12);
					for (int k = 0; k < str_len; k++) begin
						send_request(KIND_B, pick_symbol(), POS_W'($urandom),
							k == str_len - 1);
						requests++;
					end
					if (!paused || $urandom_range(19) == 0) begin
						drain_results();
						paused = 1'b1;
					end
				end else begin
					// stray B symbol, last only now and then
					send_request(KIND_B, pick_symbol(), POS_W'($urandom),
						$urandom_range(3) == 0);
					requests++;
				end
			end
			phase++;
		end

		settle_idle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
